// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level of the decoder.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/ifbsd_pkg.sv =====
// Types and constants of the intra-frame byte stream decoder.
// No dependencies.
package ifbsd_pkg;

   localparam logic [1:0] FMT_RGBA = 2'd0;
   localparam logic [1:0] FMT_RGB  = 2'd1;
   localparam logic [1:0] FMT_PAL  = 2'd2;
   localparam logic [7:0] MSK_FULL = 8'd0;
   localparam logic [7:0] MSK_BOX  = 8'd1;

   localparam logic [1:0] KIND_FILL  = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] ERR_FORMAT   = 2'd0;
   localparam logic [1:0] ERR_MASK     = 2'd1;
   localparam logic [1:0] ERR_TRUNC    = 2'd2;
   localparam logic [1:0] ERR_PAL_IDX  = 2'd3;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam int PAL_DEPTH = 256;
   localparam int PAL_WIDTH = 32;

   typedef enum logic [7:0] {
      PH_FORMAT    = 8'b0000_0001,
      PH_PAL_COUNT = 8'b0000_0010,
      PH_PAL_ENTRY = 8'b0000_0100,
      PH_MASK      = 8'b0000_1000,
      PH_RECT      = 8'b0001_0000,
      PH_BG        = 8'b0010_0000,
      PH_PIXELS    = 8'b0100_0000,
      PH_IDLE      = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [16:0] x;
      logic [16:0] y;
      logic [31:0] color;
      logic [1:0]  err;
      logic        pal;
   } res_type;

   typedef struct packed {
      logic    valid;
      logic    two;
      res_type r0;
      res_type r1;
   } evt_type;

   typedef struct packed {
      logic        we;
      logic [7:0]  addr;
      logic [31:0] data;
   } palw_type;

endpackage

// ===== rtl/ifbsd_if.sv =====
// Request and response channel interfaces.
// Depends on nothing.
interface ifbsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_frame;
   modport source (output valid, in_byte, end_of_frame, input ready);
   modport sink   (input valid, in_byte, end_of_frame, output ready);
endinterface

interface ifbsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [16:0] pixel_x;
   logic [16:0] pixel_y;
   logic [31:0] color;
   logic [1:0]  error_code;
   logic        last;
   modport source (output valid, kind, pixel_x, pixel_y, color, error_code, last,
                   input ready);
   modport sink   (input valid, kind, pixel_x, pixel_y, color, error_code, last,
                   output ready);
endinterface

// ===== rtl/ifbsd_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module ifbsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/ifbsd_parser.sv =====
// Header and pixel parser: holds parse state, yields the results of one request.
// Depends on ifbsd_pkg.
module ifbsd_parser import ifbsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  in_byte,
   input  logic        eof,
   input  logic [15:0] frame_w,
   input  logic [15:0] frame_h,
   output evt_type     evt,
   output palw_type    palw
);
   phase_type   phase_ff, phase_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic [7:0]  last_idx_ff, last_idx_in;
   logic [7:0]  entry_ff, entry_in;
   logic [2:0]  bif_ff, bif_in;
   logic [63:0] aw_ff, aw_in;
   logic [63:0] bounds_ff, bounds_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;

   logic [63:0] aw_sh;
   logic [2:0]  need;
   logic        pix_done;
   logic        pix_bad;
   logic [31:0] pix_color;
   res_type     p0, p1, errt;
   logic        p0v, p1v;

   always_comb begin
      aw_sh = {aw_ff[55:0], in_byte};
      unique case (fmt_ff)
         FMT_RGBA: need = 3'd4;
         FMT_RGB:  need = 3'd3;
         default:  need = 3'd1;
      endcase
      pix_done  = (bif_ff + 3'd1) >= need;
      pix_bad   = (fmt_ff == FMT_PAL) && (in_byte > last_idx_ff);
      pix_color = (fmt_ff == FMT_RGB) ? {aw_sh[23:0], 8'hFF} : aw_sh[31:0];
   end

   always_comb begin
      phase_in    = phase_ff;
      fmt_in      = fmt_ff;
      last_idx_in = last_idx_ff;
      entry_in    = entry_ff;
      bif_in      = bif_ff;
      aw_in       = aw_ff;
      bounds_in   = bounds_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      p0          = '0;
      p1          = '0;
      p0v         = 1'b0;
      p1v         = 1'b0;
      palw        = '0;
      palw.addr   = entry_ff;
      palw.data   = aw_sh[31:0];
      unique case (phase_ff)
         PH_FORMAT: begin
            if (in_byte <= {6'd0, FMT_PAL}) begin
               fmt_in   = in_byte[1:0];
               bif_in   = '0;
               aw_in    = '0;
               phase_in = (in_byte[1:0] == FMT_PAL) ? PH_PAL_COUNT : PH_MASK;
            end else begin
               p0v      = 1'b1;
               p0.kind  = KIND_ERROR;
               p0.err   = ERR_FORMAT;
               phase_in = PH_IDLE;
            end
         end
         PH_PAL_COUNT: begin
            last_idx_in = in_byte;
            entry_in    = '0;
            bif_in      = '0;
            aw_in       = '0;
            phase_in    = PH_PAL_ENTRY;
         end
         PH_PAL_ENTRY: begin
            aw_in  = aw_sh;
            bif_in = bif_ff + 3'd1;
            if (bif_ff == 3'd3) begin
               palw.we = 1'b1;
               bif_in  = '0;
               aw_in   = '0;
               if (entry_ff == last_idx_ff) begin
                  phase_in = PH_MASK;
               end else begin
                  entry_in = entry_ff + 8'd1;
               end
            end
         end
         PH_MASK: begin
            if (in_byte == MSK_FULL) begin
               bounds_in = {32'd0, frame_w, frame_h};
               col_in    = '0;
               row_in    = '0;
               bif_in    = '0;
               aw_in     = '0;
               if (frame_w == '0 || frame_h == '0) begin
                  p0v      = 1'b1;
                  p0.kind  = KIND_DONE;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_PIXELS;
               end
            end else if (in_byte == MSK_BOX) begin
               bif_in   = '0;
               aw_in    = '0;
               phase_in = PH_RECT;
            end else begin
               p0v      = 1'b1;
               p0.kind  = KIND_ERROR;
               p0.err   = ERR_MASK;
               phase_in = PH_IDLE;
            end
         end
         PH_RECT: begin
            aw_in  = aw_sh;
            bif_in = bif_ff + 3'd1;
            if (bif_ff == 3'd7) begin
               bounds_in = aw_sh;
               bif_in    = '0;
               aw_in     = '0;
               phase_in  = PH_BG;
            end
         end
         PH_BG: begin
            aw_in  = aw_sh;
            bif_in = bif_ff + 3'd1;
            if (pix_done) begin
               bif_in = '0;
               aw_in  = '0;
               p0v    = 1'b1;
               if (pix_bad) begin
                  p0.kind  = KIND_ERROR;
                  p0.err   = ERR_PAL_IDX;
                  phase_in = PH_IDLE;
               end else begin
                  p0.kind  = KIND_FILL;
                  p0.color = pix_color;
                  p0.pal   = (fmt_ff == FMT_PAL);
                  col_in   = '0;
                  row_in   = '0;
                  if (bounds_ff[31:16] == '0 || bounds_ff[15:0] == '0) begin
                     p1v      = 1'b1;
                     p1.kind  = KIND_DONE;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_PIXELS;
                  end
               end
            end
         end
         PH_PIXELS: begin
            aw_in  = aw_sh;
            bif_in = bif_ff + 3'd1;
            if (pix_done) begin
               bif_in = '0;
               aw_in  = '0;
               p0v    = 1'b1;
               if (pix_bad) begin
                  p0.kind  = KIND_ERROR;
                  p0.err   = ERR_PAL_IDX;
                  phase_in = PH_IDLE;
               end else begin
                  p0.kind  = KIND_PIXEL;
                  p0.x     = {1'b0, bounds_ff[63:48]} + {1'b0, col_ff};
                  p0.y     = {1'b0, bounds_ff[47:32]} + {1'b0, row_ff};
                  p0.color = pix_color;
                  p0.pal   = (fmt_ff == FMT_PAL);
                  if (({1'b0, col_ff} + 17'd1) < {1'b0, bounds_ff[31:16]}) begin
                     col_in = col_ff + 16'd1;
                  end else begin
                     col_in = '0;
                     if (({1'b0, row_ff} + 17'd1) < {1'b0, bounds_ff[15:0]}) begin
                        row_in = row_ff + 16'd1;
                     end else begin
                        p1v      = 1'b1;
                        p1.kind  = KIND_DONE;
                        phase_in = PH_IDLE;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      errt      = '0;
      errt.kind = KIND_ERROR;
      errt.err  = ERR_TRUNC;
      evt       = '0;
      evt.r0    = p0;
      evt.r1    = p1;
      evt.valid = p0v;
      evt.two   = p1v;
      if (eof) begin
         if (phase_in != PH_IDLE) begin
            if (p0v) begin
               evt.r1  = errt;
               evt.two = 1'b1;
            end else begin
               evt.r0    = errt;
               evt.valid = 1'b1;
            end
         end
         phase_in = PH_FORMAT;
         bif_in   = '0;
         aw_in    = '0;
      end
      palw.we = palw.we && take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FORMAT;
         fmt_ff      <= '0;
         last_idx_ff <= '0;
         entry_ff    <= '0;
         bif_ff      <= '0;
         aw_ff       <= '0;
         bounds_ff   <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         fmt_ff      <= fmt_in;
         last_idx_ff <= last_idx_in;
         entry_ff    <= entry_in;
         bif_ff      <= bif_in;
         aw_ff       <= aw_in;
         bounds_ff   <= bounds_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end
endmodule

// ===== rtl/iframe_byte_stream_decoder_core.sv =====
// Top level of the intra-frame byte stream decoder.
// Depends on ifbsd_pkg, ifbsd_if, ifbsd_ram, ifbsd_parser, assert_macros.svh.
//
//  channel  | dir | payload
//  req_chan | in  | in_byte, end_of_frame
//  rsp_chan | out | kind, pixel_x, pixel_y, color, error_code, last
//  csr_*    | in  | write enable, index, 16-bit data
//
// One request per cycle is taken while each result is accepted as it is shown; its results
// appear in the cycle after from the result register, one a cycle.
// A request with two results holds off the next request until its second result is taken.
// Palette colours come from the RAM's registered read, issued as the request is taken.
// A stalled response holds the result register and stops new requests.
// Reset is synchronous and clears the parse state and the result register.
`include "assert_macros.svh"
module iframe_byte_stream_decoder_core import ifbsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ifbsd_req_if.sink   req_chan,
   ifbsd_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   logic [15:0] frame_w_ff, frame_h_ff;
   evt_type     evt, ev_ff, ev_in;
   palw_type    palw;
   logic        sel_ff, sel_in;
   logic        take;
   logic        rsp_fire;
   logic        done_out;
   logic [31:0] pal_q;
   res_type     cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= 16'd256;
         frame_h_ff <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  frame_w_ff <= csr_wdata;
            CSR_HEIGHT: frame_h_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign done_out       = rsp_fire && (sel_ff || !ev_ff.two);
   assign req_chan.ready = !ev_ff.valid || done_out;
   assign take           = req_chan.valid && req_chan.ready;

   ifbsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_chan.in_byte),
      .eof     (req_chan.end_of_frame),
      .frame_w (frame_w_ff),
      .frame_h (frame_h_ff),
      .evt     (evt),
      .palw    (palw)
   );

   ifbsd_ram #(.WIDTH(PAL_WIDTH), .DEPTH(PAL_DEPTH)) u_pal (
      .clock (clock),
      .we    (palw.we),
      .waddr (palw.addr),
      .wdata (palw.data),
      .re    (take && evt.r0.pal),
      .raddr (req_chan.in_byte),
      .rdata (pal_q)
   );

   always_comb begin
      ev_in  = ev_ff;
      sel_in = sel_ff;
      if (req_chan.ready) begin
         ev_in  = take ? evt : '0;
         sel_in = 1'b0;
      end else if (rsp_fire) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff  <= '0;
         sel_ff <= 1'b0;
      end else begin
         ev_ff  <= ev_in;
         sel_ff <= sel_in;
      end
   end

   assign cur                 = sel_ff ? ev_ff.r1 : ev_ff.r0;
   assign rsp_chan.valid      = ev_ff.valid;
   assign rsp_chan.kind       = cur.kind;
   assign rsp_chan.pixel_x    = cur.x;
   assign rsp_chan.pixel_y    = cur.y;
   assign rsp_chan.color      = cur.pal ? pal_q : cur.color;
   assign rsp_chan.error_code = cur.err;
   assign rsp_chan.last       = sel_ff || !ev_ff.two;

   `ASSERT_CLK(a_sel_two, clock, reset, sel_ff |-> (ev_ff.valid && ev_ff.two), "second alone")
   `ASSERT_CLK(a_take_free, clock, reset, (take && ev_ff.valid) |-> done_out, "busy take")
   `ASSERT_CLK(a_pal_first, clock, reset, !ev_ff.r1.pal, "palette colour on second result")
   `ASSERT_CLK(a_hold, clock, reset, (rsp_chan.valid && !rsp_fire) |=> $stable(ev_ff), "held")
   `ASSERT_CLK_ALWAYS(a_reset_clear, clock, reset |=> !rsp_chan.valid, "valid after reset")
endmodule
